### hdl/uer_pkg.sv
// ============================================================================
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Request and result payload structures, configuration register indexes,
// reset values and the fixed-point distance scaling constants.
// ============================================================================
package uer_pkg;

    // One request: a single microsecond tick.
    typedef struct packed {
        logic start_req;
        logic echo_level;
    } uer_req_t;

    // One result: the block state after the tick.
    typedef struct packed {
        logic        trigger_out;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [16:0] distance_q;
    } uer_res_t;

    // Configuration register indexes (byte address is 4 * index).
    localparam logic REG_TIMEOUT_LIMIT  = 1'b0;
    localparam logic REG_TRIGGER_LENGTH = 1'b1;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_LIMIT_RESET  = 16'd30000;
    localparam logic [7:0]  TRIGGER_LENGTH_RESET = 8'd10;

    // Distance in 1/64 cm is (width * 1125) >> 10.
    localparam int          DIST_W     = 17;
    localparam logic [10:0] DIST_MULT  = 11'd1125;
    localparam int          DIST_SHIFT = 10;

endpackage

### hdl/ultrasonic_echo_ranger_unit.sv
// ============================================================================
// ultrasonic_echo_ranger_unit: echo pulse width ranging controller
// Each request is one microsecond tick carrying a start request and the
// sampled echo level; each request yields exactly one result. The block
// accepts one request every clock cycle when the result side keeps up, and a
// request passes through the input register and then the result register,
// with the phase update and the constant distance multiply between
// them. A start while idle raises the
// trigger for trigger_length ticks, then the block waits for the echo rise
// and measures the echo width, both bounded by timeout_limit (clamped to
// 2^COUNT_WIDTH - 2). The distance is reported in units of 1/64 cm and is
// cleared to zero on a timeout. Registers sit at byte address 0
// (timeout_limit, 16 bits) and 4 (trigger_length, 8 bits).
// ============================================================================
module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  uer_req_t    req_data,
    // Result channel
    output logic        res_valid,
    input  logic        res_ready,
    output uer_res_t    res_data,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CMP_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int PROD_W = COUNT_WIDTH + 11 + DIST_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [CMP_W-1:0] LIMIT_CAP = CMP_W'(COUNT_MAX) - CMP_W'(1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_WIDTH
    } phase_t;

    logic [15:0]            timeout_limit_reg;
    logic [7:0]             trigger_length_reg;

    logic                   in_valid_reg;
    uer_req_t               in_data_reg;
    logic                   res_valid_reg;
    uer_res_t               res_data_reg;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic                   tout_reg, tout_next;
    logic                   trig_next, done_next;

    logic                   advance;
    logic [CMP_W-1:0]       count_ext, limit_eff;
    logic                   over_limit, trig_end;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [PROD_W-1:0]      product;

    // Configuration writes and reads.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg  <= TIMEOUT_LIMIT_RESET;
            trigger_length_reg <= TRIGGER_LENGTH_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_TIMEOUT_LIMIT:  timeout_limit_reg  <= pwdata[15:0];
                REG_TRIGGER_LENGTH: trigger_length_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TIMEOUT_LIMIT:  prdata = {16'd0, timeout_limit_reg};
            REG_TRIGGER_LENGTH: prdata = {24'd0, trigger_length_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // Handshake: the input register moves into the result register when the
    // result register is empty or being emptied.
    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !in_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Compare helpers: clamped limit, trigger end and saturating increment.
    assign count_ext  = CMP_W'(count_reg);
    assign limit_eff  = (CMP_W'(timeout_limit_reg) < LIMIT_CAP) ?
                        CMP_W'(timeout_limit_reg) : LIMIT_CAP;
    assign over_limit = count_ext > limit_eff;
    assign trig_end   = count_ext >= CMP_W'(trigger_length_reg);
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg
                        : count_reg + COUNT_WIDTH'(1);

    // Distance of the width that ends this tick.
    assign product = PROD_W'(count_reg) * PROD_W'(DIST_MULT);

    // Phase update for the tick held in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        dist_next  = dist_reg;
        tout_next  = tout_reg;
        trig_next  = 1'b0;
        done_next  = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_data_reg.start_req)
                begin
                    phase_next = PH_TRIG;
                    count_next = COUNT_WIDTH'(1);
                    trig_next  = 1'b1;
                end
            end
            PH_TRIG:
            begin
                if (trig_end)
                begin
                    phase_next = PH_RISE;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                    trig_next  = 1'b1;
                end
            end
            PH_RISE:
            begin
                priority if (in_data_reg.echo_level)
                begin
                    phase_next = PH_WIDTH;
                    count_next = COUNT_WIDTH'(1);
                end
                else if (over_limit)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    dist_next  = '0;
                    tout_next  = 1'b1;
                    done_next  = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_WIDTH:
            begin
                priority if (!in_data_reg.echo_level)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    dist_next  = product[DIST_SHIFT +: DIST_W];
                    tout_next  = 1'b0;
                    done_next  = 1'b1;
                end
                else if (over_limit)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    dist_next  = '0;
                    tout_next  = 1'b1;
                    done_next  = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default: ;
        endcase
    end

    // State, input register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            dist_reg      <= '0;
            tout_reg      <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                dist_reg      <= dist_next;
                tout_reg      <= tout_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_data_reg <= req_data;
        end
        if (advance)
        begin
            res_data_reg.trigger_out <= trig_next;
            res_data_reg.busy_res    <= (phase_next != PH_IDLE);
            res_data_reg.done_res    <= done_next;
            res_data_reg.timed_out   <= tout_next;
            res_data_reg.distance_q  <= dist_next;
        end
    end

endmodule

### verif/uer_range_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// uer_range_checker: result predictor and scoreboard for the echo ranger
// Watches the request, result and configuration ports of the ranger. Every
// accepted tick request is run through a local copy of the ranging state
// machine, and every accepted result is compared field by field, in order,
// with the oldest predicted result. Register read-backs are checked as well.
// ============================================================================
module uer_range_checker
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  uer_req_t    req_data,
    input  logic        res_valid,
    input  logic        res_ready,
    input  uer_res_t    res_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_count,
    output logic        ranger_busy
);

    typedef enum logic [1:0] {
        RANGER_IDLE,
        RANGER_TRIGGER,
        RANGER_RISE_WAIT,
        RANGER_WIDTH
    } ranger_phase_e;

    // Counter saturation value and the clamp that keeps a timeout reachable.
    localparam logic [15:0] TICK_SAT      = 16'hFFFF;
    localparam logic [15:0] LIMIT_CAP     = 16'hFFFE;
    localparam logic [31:0] CM64_PER_TICK = 32'd1125;
    localparam int          CM64_SHIFT    = 10;

    logic [15:0]   limit_reg;
    logic [7:0]    trig_len_reg;
    ranger_phase_e phase_q;
    logic [15:0]   ticks;
    logic [16:0]   last_dist;
    logic          timeout_sticky;
    uer_res_t      results_due[$];
    int            result_idx;

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
        ranger_busy    = 1'b0;
        result_idx     = 0;
    end

    // One line per mismatch, and the count that the top turns into a verdict.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $time, result_idx, msg);
        mismatch_count++;
    endtask

    task automatic bump_ticks();
        if (ticks != TICK_SAT)
            ticks++;
    endtask

    // Close a measurement, either with a distance or with the timeout flag.
    task automatic finish_measurement(input logic by_timeout);
        logic [31:0] scaled;
        scaled = {16'd0, ticks} * CM64_PER_TICK;
        if (by_timeout) begin
            timeout_sticky = 1'b1;
            last_dist      = '0;
        end
        else begin
            timeout_sticky = 1'b0;
            last_dist      = scaled[CM64_SHIFT +: 17];
        end
        phase_q = RANGER_IDLE;
        ticks   = '0;
    endtask

    // Advance the ranging state machine by one tick and form its result.
    task automatic step_ranger(input uer_req_t rq, output uer_res_t rs);
        logic        trig;
        logic        done;
        logic [15:0] lim;
        trig = 1'b0;
        done = 1'b0;
        lim  = (limit_reg < LIMIT_CAP) ? limit_reg : LIMIT_CAP;
        case (phase_q)
            RANGER_IDLE:
            begin
                if (rq.start_req) begin
                    phase_q = RANGER_TRIGGER;
                    ticks   = 16'd1;
                    trig    = 1'b1;
                end
            end
            RANGER_TRIGGER:
            begin
                // A zero trigger length ends after the start tick, like one.
                if (ticks >= {8'd0, trig_len_reg}) begin
                    phase_q = RANGER_RISE_WAIT;
                    ticks   = '0;
                end
                else begin
                    bump_ticks();
                    trig = 1'b1;
                end
            end
            RANGER_RISE_WAIT:
            begin
                if (rq.echo_level) begin
                    phase_q = RANGER_WIDTH;
                    ticks   = 16'd1;
                end
                else if (ticks > lim) begin
                    finish_measurement(1'b1);
                    done = 1'b1;
                end
                else begin
                    bump_ticks();
                end
            end
            default:
            begin
                if (!rq.echo_level) begin
                    finish_measurement(1'b0);
                    done = 1'b1;
                end
                else if (ticks > lim) begin
                    finish_measurement(1'b1);
                    done = 1'b1;
                end
                else begin
                    bump_ticks();
                end
            end
        endcase
        rs.trigger_out = trig;
        rs.busy_res    = (phase_q != RANGER_IDLE);
        rs.done_res    = done;
        rs.timed_out   = timeout_sticky;
        rs.distance_q  = last_dist;
    endtask

    // Compare one accepted result with the oldest prediction.
    task automatic check_result(input uer_res_t got);
        uer_res_t want;
        if (results_due.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
        end
        else begin
            want = results_due.pop_front();
            if (got.trigger_out !== want.trigger_out)
                report_mismatch($sformatf("trigger_out %b, predicted %b",
                                          got.trigger_out, want.trigger_out));
            if (got.busy_res !== want.busy_res)
                report_mismatch($sformatf("busy_res %b, predicted %b",
                                          got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                report_mismatch($sformatf("done_res %b, predicted %b",
                                          got.done_res, want.done_res));
            if (got.timed_out !== want.timed_out)
                report_mismatch($sformatf("timed_out %b, predicted %b",
                                          got.timed_out, want.timed_out));
            if (got.distance_q !== want.distance_q)
                report_mismatch($sformatf("distance_q %0d, predicted %0d",
                                          got.distance_q, want.distance_q));
        end
        result_idx++;
    endtask

    // Watch all three ports at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        uer_res_t predicted;
        if (!rst_n) begin
            limit_reg      = TIMEOUT_LIMIT_RESET;
            trig_len_reg   = TRIGGER_LENGTH_RESET;
            phase_q        = RANGER_IDLE;
            ticks          = '0;
            last_dist      = '0;
            timeout_sticky = 1'b0;
            results_due.delete();
        end
        else begin
            // Results leave before this edge's request can add a prediction.
            if (res_valid && res_ready)
                check_result(res_data);
            if (req_valid && req_ready) begin
                step_ranger(req_data, predicted);
                results_due.push_back(predicted);
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[2])
                        REG_TIMEOUT_LIMIT:  limit_reg    = pwdata[15:0];
                        REG_TRIGGER_LENGTH: trig_len_reg = pwdata[7:0];
                        default: ;
                    endcase
                end
                else begin
                    case (paddr[2])
                        REG_TIMEOUT_LIMIT:
                            if (prdata[15:0] !== limit_reg)
                                report_mismatch($sformatf("timeout_limit reads %0d, holds %0d",
                                                          prdata[15:0], limit_reg));
                        REG_TRIGGER_LENGTH:
                            if (prdata[7:0] !== trig_len_reg)
                                report_mismatch($sformatf("trigger_length reads %0d, holds %0d",
                                                          prdata[7:0], trig_len_reg));
                        default: ;
                    endcase
                end
            end
        end
        pending_count = results_due.size();
        ranger_busy   = (phase_q != RANGER_IDLE);
    end

endmodule

### verif/ultrasonic_echo_ranger_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// ultrasonic_echo_ranger_unit_tb: stimulus and verdict for the echo ranger
// Drives microsecond tick requests and register writes into the ranger with
// random gaps and result-side stalls. A directed opening covers idle noise,
// starts while busy, the largest limit and trigger length, and the zero
// settings; random phases then run measurements with random content, noise
// and broken sequences. The checker beside the block does all comparison.
// ============================================================================
module ultrasonic_echo_ranger_unit_tb;
    import uer_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    uer_req_t    req_data;
    logic        res_valid;
    logic        res_ready;
    uer_res_t    res_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pending_count;
    logic        ranger_busy;

    // When set, neither side idles between requests.
    bit          no_gaps;
    int          ticks_sent;
    int          measurements;
    int          settings;
    int          cur_trig_len;

    ultrasonic_echo_ranger_unit DUT (.*);

    uer_range_checker u_checker (.*);

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: accept one result per handshake after a random stall.
    initial
    begin
        int gap;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                res_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ready = 1'b1;
            do @(posedge clk); while (!res_valid);
            @(negedge clk);
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Send one tick request after a random gap; returns at a falling edge.
    task automatic send_tick(input logic start, input logic echo);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid          = 1'b1;
        req_data.start_req  = start;
        req_data.echo_level = echo;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    // One measurement: start, trigger ticks, rise wait, echo width, falling edge.
    task automatic measure(input int rise_len, input int high_len, input bit noisy);
        int trig_ticks;
        trig_ticks = (cur_trig_len == 0) ? 1 : cur_trig_len;
        measurements++;
        send_tick(1'b1, coin());
        repeat (trig_ticks) send_tick(noisy & coin(), coin());
        repeat (rise_len) send_tick(noisy & coin(), 1'b0);
        repeat (high_len) send_tick(noisy & coin(), 1'b1);
        send_tick(noisy & coin(), 1'b0);
    endtask

    // Register write followed by a read-back of the same register.
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Bring the ranger back to idle, then wait until every result is in.
    task automatic settle_and_drain();
        logic echo_t;
        echo_t = 1'b1;
        while (ranger_busy) begin
            send_tick(1'b0, echo_t);
            echo_t = ~echo_t;
        end
        req_valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(input int limit, input int trig_len);
        settle_and_drain();
        write_register(REG_TIMEOUT_LIMIT, limit);
        write_register(REG_TRIGGER_LENGTH, trig_len);
        cur_trig_len = trig_len;
        settings++;
    endtask

    // Main stimulus.
    initial
    begin
        int lim;
        int trig;
        int cap;
        int kind;
        int waited;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        no_gaps      = 1'b0;
        ticks_sent   = 0;
        measurements = 0;
        settings     = 1;
        cur_trig_len = TRIGGER_LENGTH_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: idle noise, then a clean measurement and one with starts while busy.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        measure(2, 4, 1'b0);
        measure(2, 4, 1'b1);

        // Largest limit, clamped inside the block, and the longest trigger,
        // sent back to back.
        apply_settings(16'hFFFF, 8'd255);
        no_gaps = 1'b1;
        measure(3, 5, 1'b0);
        no_gaps = 1'b0;

        // Zero limit and zero trigger length.
        apply_settings(0, 0);
        measure(0, 1, 1'b0);
        measure(2, 0, 1'b0);
        measure(0, 3, 1'b0);
        measure(1, 1, 1'b1);

        // Random phases, each with its own settings.
        while (ticks_sent < 450) begin
            case ($urandom_range(0, 3))
                0:       lim = 1;
                1:       lim = $urandom_range(2, 12);
                2:       lim = $urandom_range(13, 40);
                default: lim = $urandom_range(41, 65535);
            endcase
            trig = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 6);
            apply_settings(lim, trig);
            cap = (lim + 3 > 40) ? 40 : lim + 3;
            repeat ($urandom_range(2, 5)) begin
                if (ticks_sent >= 450)
                    break;
                no_gaps = ($urandom_range(0, 5) == 0);
                kind    = $urandom_range(0, 9);
                if (kind <= 6) begin
                    measure($urandom_range(0, cap), $urandom_range(1, cap), 1'b0);
                end
                else if (kind == 7) begin
                    measure($urandom_range(0, cap), $urandom_range(0, cap), 1'b1);
                end
                else if (kind == 8) begin
                    repeat ($urandom_range(1, 8)) send_tick(coin(), coin());
                end
                else begin
                    // Broken sequence: a start followed by random echo levels.
                    send_tick(1'b1, coin());
                    repeat ($urandom_range(1, cap)) send_tick(1'b0, coin());
                end
            end
            no_gaps = 1'b0;
        end

        // Wait out the remaining results, with a bound.
        req_valid = 1'b0;
        waited    = 0;
        while (pending_count != 0 && waited < 2000) begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);

        if (pending_count != 0)
            $display("%0d results never arrived", pending_count);
        $display("Covered %0d tick requests in %0d scripted measurements over %0d settings,",
                 ticks_sent, measurements, settings);
        $display("with clamped and zero limits, trigger lengths 0 to 255, noise and stalls.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
hdl/uer_pkg.sv
hdl/ultrasonic_echo_ranger_unit.sv
verif/uer_range_checker.sv
verif/ultrasonic_echo_ranger_unit_tb.sv
